>>> design/rmts_pkg.sv
// Package for the rate monotonic task scheduler.
// Types, opcodes, status codes and sizes. No dependencies.
package rmts_pkg;
  localparam int SLOTS = 16;
  localparam int FRAC_BITS = 20;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SHARE_W = 21;
  localparam int ID_W = 22;
  localparam int DIV_W = 16 + FRAC_BITS;
  localparam logic [SHARE_W-1:0] UTIL_LIMIT_RST = SHARE_W'(726663);

  typedef enum logic [2:0] {
    OP_REG = 3'd0, OP_DEREG = 3'd1, OP_YIELD = 3'd2, OP_RELEASE = 3'd3, OP_PICK = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DUP = 3'd1, ST_OVER = 3'd2, ST_NOTFOUND = 3'd3,
    ST_MISS = 3'd4, ST_FULL = 3'd5, ST_NONE = 3'd6, ST_ZERO = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DIV, S_EXEC, S_OUT
  } state_t;

  // divider control and status
  typedef struct packed {
    logic start;
    logic [15:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;
endpackage

>>> design/rmts_divider.sv
// Restoring serial divider: (num << FRAC_BITS) / den, one quotient bit per cycle.
// Depends on rmts_pkg.
module rmts_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  rmts_pkg::div_req_t req,
  output rmts_pkg::div_rsp_t rsp
);
  localparam int CNT_W = $clog2(rmts_pkg::DIV_W + 1);
  logic [rmts_pkg::DIV_W-1:0] dvd_r, dvd_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [16:0] trial;
  logic [16:0] diff;

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    trial = {rem_r, dvd_r[rmts_pkg::DIV_W-1]};
    diff = trial - {1'b0, den_r};
    if (req.start) begin
      dvd_nxt = {req.num, {rmts_pkg::FRAC_BITS{1'b0}}};
      rem_nxt = '0;
      den_nxt = req.den;
      cnt_nxt = CNT_W'(rmts_pkg::DIV_W);
    end else if (cnt_r != '0) begin
      // shift in one dividend bit, subtract if it fits (remainder stays below den)
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[15:0];
        dvd_nxt = {dvd_r[rmts_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        dvd_nxt = {dvd_r[rmts_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.quot = dvd_r;
endmodule

>>> design/rate_monotonic_task_scheduler.sv
// Top level of the rate monotonic task scheduler: slot table, scan sequencer,
// admission arithmetic. Depends on rmts_pkg and rmts_divider.
//
// Usage: a command beat enters on in_valid/in_ready (op, task_id, period_ticks,
// compute_ticks, now). The block then walks the 16 slots one per cycle with one
// shared compare unit (id match, free slot, best ready task), and for a
// register command with a new id and a nonzero period runs a serial
// division for the share. One result beat (status, chosen_id, deadline,
// util_sum) leaves on out_valid/out_ready. in_ready is high only while idle
// with no result pending, so no new command is taken before the last result
// beat has been taken. The result register holds while the receiver stalls.
// cfg_we writes util_limit at once; the user must write it only while idle,
// as the block itself does not enforce this.
// Synchronous reset clears all slot valid bits, the sum, the order counter
// and restores util_limit to 726663; the table needs no clearing pass.
module rate_monotonic_task_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [21:0] in_task_id,
  input  logic [15:0] in_period_ticks,
  input  logic [15:0] in_compute_ticks,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [21:0] out_chosen_id,
  output logic [31:0] out_deadline,
  output logic [20:0] out_util_sum
);
  localparam int SW = rmts_pkg::SLOT_W;
  localparam int N = rmts_pkg::SLOTS;

  // slot table
  logic [N-1:0] valid_r, ready_r, started_r;
  logic [rmts_pkg::ID_W-1:0] id_r [N];
  logic [15:0] period_r [N];
  logic [rmts_pkg::SHARE_W-1:0] share_r [N];
  logic [31:0] dl_r [N];
  logic [15:0] order_r [N];
  logic [15:0] ocnt_r;
  logic [rmts_pkg::SHARE_W-1:0] total_r, limit_r;

  rmts_pkg::state_t state_r, state_nxt;
  logic [2:0] op_r;
  logic [21:0] tid_r;
  logic [15:0] per_r, comp_r;
  logic [31:0] now_r;
  logic [SW-1:0] idx_r, idx_nxt;
  logic hit_r, hit_nxt, fr_r, fr_nxt, bst_r, bst_nxt;
  logic [SW-1:0] hidx_r, hidx_nxt, fidx_r, fidx_nxt, bidx_r, bidx_nxt;
  logic [15:0] bper_r, bper_nxt, bage_r, bage_nxt;
  logic [2:0] st_r;
  logic [21:0] cid_r;
  logic [31:0] odl_r;
  logic ov_r;

  rmts_pkg::div_req_t dreq;
  rmts_pkg::div_rsp_t drsp;
  rmts_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [15:0] age_i;
  logic [rmts_pkg::DIV_W:0] sum_w;
  logic [31:0] dl_new;

  assign in_ready = (state_r == rmts_pkg::S_IDLE) && !ov_r;
  assign age_i = ocnt_r - order_r[idx_r];
  assign sum_w = (rmts_pkg::DIV_W+1)'(total_r) + (rmts_pkg::DIV_W+1)'(drsp.quot);
  assign dl_new = (started_r[hidx_r] ? dl_r[hidx_r] : now_r) + 32'(period_r[hidx_r]);

  // sequencer and scan step: one slot compared per cycle while scanning
  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    hit_nxt = hit_r; hidx_nxt = hidx_r;
    fr_nxt = fr_r; fidx_nxt = fidx_r;
    bst_nxt = bst_r; bidx_nxt = bidx_r; bper_nxt = bper_r; bage_nxt = bage_r;
    dreq.start = 1'b0;
    dreq.num = comp_r;
    dreq.den = per_r;
    unique case (state_r)
      rmts_pkg::S_IDLE: begin
        idx_nxt = '0;
        hit_nxt = 1'b0; fr_nxt = 1'b0; bst_nxt = 1'b0;
        if (in_valid && in_ready) state_nxt = rmts_pkg::S_SCAN;
      end
      rmts_pkg::S_SCAN: begin
        if (valid_r[idx_r] && id_r[idx_r] == tid_r && !hit_r) begin
          hit_nxt = 1'b1; hidx_nxt = idx_r;
        end
        if (!valid_r[idx_r] && !fr_r) begin
          fr_nxt = 1'b1; fidx_nxt = idx_r;
        end
        if (valid_r[idx_r] && ready_r[idx_r] &&
            (!bst_r || period_r[idx_r] < bper_r ||
             (period_r[idx_r] == bper_r && age_i > bage_r))) begin
          bst_nxt = 1'b1; bidx_nxt = idx_r;
          bper_nxt = period_r[idx_r]; bage_nxt = age_i;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == SW'(N-1)) begin
          if (op_r == rmts_pkg::OP_REG && !hit_nxt && per_r != '0) begin
            dreq.start = 1'b1;
            state_nxt = rmts_pkg::S_DIV;
          end else begin
            state_nxt = rmts_pkg::S_EXEC;
          end
        end
      end
      rmts_pkg::S_DIV: begin
        if (!drsp.busy) state_nxt = rmts_pkg::S_EXEC;
      end
      rmts_pkg::S_EXEC: state_nxt = rmts_pkg::S_OUT;
      rmts_pkg::S_OUT: begin
        if (out_ready) state_nxt = rmts_pkg::S_IDLE;
      end
      default: state_nxt = rmts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmts_pkg::S_IDLE;
      valid_r <= '0;
      ocnt_r <= '0;
      total_r <= '0;
      limit_r <= rmts_pkg::UTIL_LIMIT_RST;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
      if (state_r == rmts_pkg::S_OUT && out_ready) ov_r <= 1'b0;
      // apply the command and form the result
      if (state_r == rmts_pkg::S_EXEC) begin
        ov_r <= 1'b1;
        st_r <= rmts_pkg::ST_OK;
        cid_r <= '0;
        odl_r <= '0;
        case (op_r)
          rmts_pkg::OP_REG: begin
            if (hit_r) st_r <= rmts_pkg::ST_DUP;
            else if (per_r == '0) st_r <= rmts_pkg::ST_ZERO;
            else if (sum_w >= (rmts_pkg::DIV_W+1)'(limit_r)) st_r <= rmts_pkg::ST_OVER;
            else if (!fr_r) st_r <= rmts_pkg::ST_FULL;
            else begin
              valid_r[fidx_r] <= 1'b1;
              id_r[fidx_r] <= tid_r;
              period_r[fidx_r] <= per_r;
              share_r[fidx_r] <= drsp.quot[rmts_pkg::SHARE_W-1:0];
              dl_r[fidx_r] <= '0;
              ready_r[fidx_r] <= 1'b0;
              started_r[fidx_r] <= 1'b0;
              order_r[fidx_r] <= ocnt_r;
              ocnt_r <= ocnt_r + 1'b1;
              total_r <= sum_w[rmts_pkg::SHARE_W-1:0];
            end
          end
          rmts_pkg::OP_DEREG: begin
            if (!hit_r) st_r <= rmts_pkg::ST_NOTFOUND;
            else begin
              total_r <= total_r - share_r[hidx_r];
              valid_r[hidx_r] <= 1'b0;
              ready_r[hidx_r] <= 1'b0;
            end
          end
          rmts_pkg::OP_YIELD: begin
            if (!hit_r) st_r <= rmts_pkg::ST_NOTFOUND;
            else begin
              dl_r[hidx_r] <= dl_new;
              odl_r <= dl_new;
              started_r[hidx_r] <= 1'b1;
              if (started_r[hidx_r] && now_r > dl_new) st_r <= rmts_pkg::ST_MISS;
              else ready_r[hidx_r] <= 1'b0;
            end
          end
          rmts_pkg::OP_RELEASE: begin
            if (!hit_r) st_r <= rmts_pkg::ST_NOTFOUND;
            else ready_r[hidx_r] <= 1'b1;
          end
          rmts_pkg::OP_PICK: begin
            if (!bst_r) st_r <= rmts_pkg::ST_NONE;
            else cid_r <= id_r[bidx_r];
          end
          default: ;
        endcase
      end
    end
    if (in_valid && in_ready) begin
      op_r <= in_op; tid_r <= in_task_id; per_r <= in_period_ticks;
      comp_r <= in_compute_ticks; now_r <= in_now;
    end
    idx_r <= idx_nxt;
    hit_r <= hit_nxt; hidx_r <= hidx_nxt;
    fr_r <= fr_nxt; fidx_r <= fidx_nxt;
    bst_r <= bst_nxt; bidx_r <= bidx_nxt; bper_r <= bper_nxt; bage_r <= bage_nxt;
  end

  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_chosen_id = cid_r;
  assign out_deadline = odl_r;
  assign out_util_sum = total_r;

`ifndef SYNTHESIS
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rmts_pkg::S_IDLE) |-> !in_ready)
    else $error("input accepted while busy");
  a_out_in_outstate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == rmts_pkg::S_OUT))
    else $error("result valid outside output state");
  a_div_done_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmts_pkg::S_EXEC && op_r == rmts_pkg::OP_REG) |-> !drsp.busy)
    else $error("divider busy at commit");
`endif
endmodule

>>> sim/rate_monotonic_task_scheduler_tb.sv
// Testbench for the rate monotonic task scheduler: directed and random command beats,
// checked against an in-bench scheduler predictor. Depends on rmts_pkg and the RTL.
module rate_monotonic_task_scheduler_tb;

  typedef struct packed {
    logic [2:0] op;
    logic [21:0] task_id;
    logic [15:0] period;
    logic [15:0] compute;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [21:0] chosen;
    logic [31:0] deadline;
    logic [20:0] util;
  } rsp_t;

  localparam int WATCHDOG = 20000;
  // opcodes outside the defined set, expected to be ignored
  localparam logic [2:0] OP_BAD_LO = 3'd5;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  logic clk, rst_n;
  logic cfg_we;
  logic [20:0] cfg_wdata;
  logic in_valid, in_ready;
  logic [2:0] in_op;
  logic [21:0] in_task_id;
  logic [15:0] in_period_ticks, in_compute_ticks;
  logic [31:0] in_now;
  logic out_valid, out_ready;
  logic [2:0] out_status;
  logic [21:0] out_chosen_id;
  logic [31:0] out_deadline;
  logic [20:0] out_util_sum;

  rate_monotonic_task_scheduler u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_task_id(in_task_id),
    .in_period_ticks(in_period_ticks), .in_compute_ticks(in_compute_ticks),
    .in_now(in_now), .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_chosen_id(out_chosen_id),
    .out_deadline(out_deadline), .out_util_sum(out_util_sum)
  );

  // clock: period 12
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the task table
  logic [20:0] lim;
  logic        tv [rmts_pkg::SLOTS];
  logic [21:0] tid [rmts_pkg::SLOTS];
  logic [15:0] tper [rmts_pkg::SLOTS];
  logic [20:0] tshare [rmts_pkg::SLOTS];
  logic [31:0] tdl [rmts_pkg::SLOTS];
  logic        trdy [rmts_pkg::SLOTS];
  logic [15:0] tord [rmts_pkg::SLOTS];
  logic        tstart [rmts_pkg::SLOTS];
  logic [15:0] reg_count;
  logic [20:0] sum_share;

  cmd_t cmd_q[$];
  rsp_t rsp_q[$];
  int errors = 0;
  int sent = 0, got = 0;
  int in_idle_pct = 0, out_idle_pct = 0;
  bit hold_out = 0;
  bit hold_go = 0;
  int quiet = 0;
  int hist_st[8];
  logic in_ready_seen = 1'b0;

  function automatic int lookup(logic [21:0] id);
    for (int i = 0; i < rmts_pkg::SLOTS; i++)
      if (tv[i] && tid[i] == id) return i;
    return -1;
  endfunction

  // compute the result of one command and update the table
  function automatic rsp_t schedule_cmd(cmd_t c);
    rsp_t r;
    int s, best, fr;
    logic [63:0] share;
    logic [15:0] ai, ab;
    r = '0;
    r.status = rmts_pkg::ST_OK;
    case (c.op)
      rmts_pkg::OP_REG: begin
        fr = -1;
        if (lookup(c.task_id) >= 0) r.status = rmts_pkg::ST_DUP;
        else if (c.period == '0) r.status = rmts_pkg::ST_ZERO;
        else begin
          share = ({48'd0, c.compute} << rmts_pkg::FRAC_BITS) / {48'd0, c.period};
          if ({43'd0, sum_share} + share >= {43'd0, lim}) r.status = rmts_pkg::ST_OVER;
          else begin
            for (int i = rmts_pkg::SLOTS - 1; i >= 0; i--) if (!tv[i]) fr = i;
            if (fr < 0) r.status = rmts_pkg::ST_FULL;
            else begin
              tv[fr] = 1'b1; tid[fr] = c.task_id; tper[fr] = c.period;
              tshare[fr] = share[20:0]; tdl[fr] = '0; trdy[fr] = 1'b0;
              tstart[fr] = 1'b0; tord[fr] = reg_count;
              reg_count = reg_count + 16'd1;
              sum_share = sum_share + share[20:0];
            end
          end
        end
      end
      rmts_pkg::OP_DEREG: begin
        s = lookup(c.task_id);
        if (s < 0) r.status = rmts_pkg::ST_NOTFOUND;
        else begin
          sum_share = sum_share - tshare[s];
          tv[s] = 1'b0; trdy[s] = 1'b0;
        end
      end
      rmts_pkg::OP_YIELD: begin
        s = lookup(c.task_id);
        if (s < 0) r.status = rmts_pkg::ST_NOTFOUND;
        else if (!tstart[s]) begin
          tstart[s] = 1'b1; tdl[s] = c.now + 32'(tper[s]); trdy[s] = 1'b0;
          r.deadline = tdl[s];
        end else begin
          tdl[s] = tdl[s] + 32'(tper[s]);
          r.deadline = tdl[s];
          if (c.now > tdl[s]) r.status = rmts_pkg::ST_MISS;
          else trdy[s] = 1'b0;
        end
      end
      rmts_pkg::OP_RELEASE: begin
        s = lookup(c.task_id);
        if (s < 0) r.status = rmts_pkg::ST_NOTFOUND;
        else trdy[s] = 1'b1;
      end
      rmts_pkg::OP_PICK: begin
        best = -1;
        for (int i = 0; i < rmts_pkg::SLOTS; i++) begin
          if (tv[i] && trdy[i]) begin
            if (best < 0 || tper[i] < tper[best]) best = i;
            else if (tper[i] == tper[best]) begin
              ai = reg_count - tord[i];
              ab = reg_count - tord[best];
              if (ai > ab) best = i;
            end
          end
        end
        if (best < 0) r.status = rmts_pkg::ST_NONE;
        else r.chosen = tid[best];
      end
      default: ;
    endcase
    r.util = sum_share;
    return r;
  endfunction

  // driver: present queued beats at the falling edge, hold until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready_seen)) begin
      if (cmd_q.size() > 0 && $urandom_range(99, 0) >= in_idle_pct) begin
        cmd_t c;
        c = cmd_q.pop_front();
        in_valid <= 1'b1;
        in_op <= c.op; in_task_id <= c.task_id; in_period_ticks <= c.period;
        in_compute_ticks <= c.compute; in_now <= c.now;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accept bookkeeping at the rising edge
  always @(posedge clk) begin
    in_ready_seen <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      rsp_q.push_back(schedule_cmd({in_op, in_task_id, in_period_ticks,
                                    in_compute_ticks, in_now}));
      sent++;
    end
  end

  // long receiver hold, timed in cycles here
  initial begin
    wait (hold_go);
    @(negedge clk);
    hold_out = 1'b1;
    repeat (400) @(negedge clk);
    hold_out = 1'b0;
  end

  // receiver ready
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_out && ($urandom_range(99, 0) >= out_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      rsp_t e;
      got++;
      if (rsp_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: %h", $time,
                 {out_status, out_chosen_id, out_deadline, out_util_sum});
        errors++;
      end else begin
        e = rsp_q.pop_front();
        hist_st[out_status]++;
        if (e.status !== out_status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
          errors++;
        end
        if (e.chosen !== out_chosen_id) begin
          $display("%0t: chosen_id exp %h got %h", $time, e.chosen, out_chosen_id);
          errors++;
        end
        if (e.deadline !== out_deadline) begin
          $display("%0t: deadline exp %h got %h", $time, e.deadline, out_deadline);
          errors++;
        end
        if (e.util !== out_util_sum) begin
          $display("%0t: util_sum exp %h got %h", $time, e.util, out_util_sum);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without a beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("%0t: watchdog expired, %0d beats still expected", $time, rsp_q.size());
      $display("rate_monotonic_task_scheduler_tb: errors");
      $finish;
    end
  end

  task automatic push(logic [2:0] op, logic [21:0] id, logic [15:0] p,
                      logic [15:0] c, logic [31:0] n);
    cmd_q.push_back({op, id, p, c, n});
  endtask

  // wait for the pipeline to empty; extra cycles cover trailing work
  task automatic drain();
    while (cmd_q.size() > 0 || in_valid || rsp_q.size() > 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_limit(logic [20:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    lim = v;
  endtask

  // random mix: mostly well-formed traffic over a small pool of ids
  task automatic random_block(int n);
    logic [21:0] pool [8];
    logic [21:0] id;
    logic [31:0] t;
    int k;
    for (int i = 0; i < 8; i++) pool[i] = 22'($urandom);
    t = $urandom;
    for (int i = 0; i < n; i++) begin
      id = ($urandom_range(9, 0) == 0) ? 22'($urandom) : pool[$urandom_range(7, 0)];
      k = $urandom_range(99, 0);
      t = t + $urandom_range(300, 0);
      if (k < 25)
        push(rmts_pkg::OP_REG, id, ($urandom_range(19, 0) == 0) ? 16'd0 :
             16'($urandom_range(65535, 1)), 16'($urandom), $urandom);
      else if (k < 35)
        push(rmts_pkg::OP_DEREG, id, 16'($urandom), 16'($urandom), $urandom);
      else if (k < 55)
        push(rmts_pkg::OP_YIELD, id, 16'($urandom), 16'($urandom),
             ($urandom_range(3, 0) == 0) ? $urandom : t);
      else if (k < 75)
        push(rmts_pkg::OP_RELEASE, id, 16'($urandom), 16'($urandom), $urandom);
      else if (k < 97)
        push(rmts_pkg::OP_PICK, id, 16'($urandom), 16'($urandom), $urandom);
      else
        push(3'($urandom_range(7, 5)), id, 16'($urandom), 16'($urandom), $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0; in_valid = 1'b0;
    in_op = '0; in_task_id = '0; in_period_ticks = '0; in_compute_ticks = '0;
    in_now = '0; out_ready = 1'b0;
    lim = rmts_pkg::UTIL_LIMIT_RST;
    for (int i = 0; i < rmts_pkg::SLOTS; i++) begin
      tv[i] = 1'b0; tid[i] = '0; tper[i] = '0; tshare[i] = '0; tdl[i] = '0;
      trdy[i] = 1'b0; tord[i] = '0; tstart[i] = 1'b0;
    end
    reg_count = '0; sum_share = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: empty picks, zero period, duplicate, over limit, misses, ties
    push(rmts_pkg::OP_PICK, '0, '0, '0, '0);
    push(rmts_pkg::OP_DEREG, 22'h3FFFFF, '0, '0, '0);
    push(rmts_pkg::OP_REG, 22'h3FFFFF, 16'd0, 16'd5, '0);
    push(rmts_pkg::OP_REG, 22'h3FFFFF, 16'hFFFF, 16'd0, '0);
    push(rmts_pkg::OP_REG, 22'h3FFFFF, 16'd10, 16'd1, '0);
    push(rmts_pkg::OP_REG, 22'd0, 16'd1, 16'hFFFF, '0);
    push(rmts_pkg::OP_REG, 22'd0, 16'd100, 16'd10, '0);
    push(rmts_pkg::OP_REG, 22'd7, 16'd100, 16'd10, '0);
    push(rmts_pkg::OP_RELEASE, 22'd7, '0, '0, '0);
    push(rmts_pkg::OP_RELEASE, 22'd0, '0, '0, '0);
    push(rmts_pkg::OP_PICK, '0, '0, '0, '0);
    push(rmts_pkg::OP_YIELD, 22'd0, '0, '0, 32'hFFFFFFF0);
    push(rmts_pkg::OP_YIELD, 22'd0, '0, '0, 32'hFFFFFFFF);
    push(rmts_pkg::OP_YIELD, 22'd0, '0, '0, 32'd0);
    push(rmts_pkg::OP_RELEASE, 22'd5, '0, '0, '0);
    push(rmts_pkg::OP_PICK, '0, '0, '0, '0);
    push(OP_BAD_LO, 22'd1, '0, '0, '0);
    push(OP_BAD_HI, 22'd1, '0, '0, '0);
    push(rmts_pkg::OP_DEREG, 22'd7, '0, '0, '0);
    push(rmts_pkg::OP_PICK, '0, '0, '0, '0);
    drain();
    // fill the table with cheap tasks
    write_limit(21'h1FFFFF);
    for (int i = 0; i < 17; i++)
      push(rmts_pkg::OP_REG, 22'(100 + i), 16'hFFFF, 16'd1, '0);
    push(rmts_pkg::OP_PICK, '0, '0, '0, '0);
    drain();
    write_limit(21'd0);
    push(rmts_pkg::OP_REG, 22'd999, 16'd1, 16'd0, '0);
    drain();

    // random phases across limits and idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 69 : 0;
      out_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 20 : 0;
      write_limit(ph == 0 ? 21'd1048576 : ph == 1 ? rmts_pkg::UTIL_LIMIT_RST : 21'h1FFFFF);
      for (int i = 0; i < rmts_pkg::SLOTS; i++)
        push(rmts_pkg::OP_DEREG, tid[i], '0, '0, '0);
      random_block(400);
      if (ph == 1) begin
        // long receiver hold while commands keep coming
        repeat (40) @(posedge clk);
        hold_go = 1'b1;
      end
      drain();
    end

    $display("covered %0d commands, %0d results; ok %0d dup %0d over %0d", sent, got,
             hist_st[0], hist_st[1], hist_st[2]);
    $display("notfound %0d miss %0d full %0d none %0d zero %0d", hist_st[3], hist_st[4],
             hist_st[5], hist_st[6], hist_st[7]);
    if (errors == 0) $display("rate_monotonic_task_scheduler_tb: clean");
    else $display("rate_monotonic_task_scheduler_tb: errors");
    $finish;
  end
endmodule
